// ===== src/assert_macros.svh =====
// Assertion macros shared by the sampler RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define AWPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define AWPS_NEVER(lbl, cond, msg) \
  `AWPS_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/awps_pkg.sv =====
// Shared types and constants of the alignment window point sampler.
// No dependencies; the controller, datapath, top level and testbench import this package.
package awps_pkg;

  // Default widths of positions and of the window step.
  localparam int POS_WIDTH_DEF   = 32;
  localparam int STEP_WIDTH_DEF  = 16;
  // Fixed width of the reported positions.
  localparam int OUT_POS_WIDTH   = 32;
  // Configuration index width; indexes past the register list are ignored.
  localparam int CFG_IDX_WIDTH   = 4;
  // Reset value of the window step.
  localparam int SAMPLE_STEP_RST = 500;
  // Number of offsets tested against the boundaries.
  localparam int NUM_LANES       = 9;

  typedef enum logic [1:0] {
    OP_MATCH    = 2'd0,
    OP_INS      = 2'd1,
    OP_DEL      = 2'd2,
    OP_MISMATCH = 2'd3
  } edit_op_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_QUERY_START = 4'd0,
    REG_QUERY_END   = 4'd1,
    REG_QUERY_LEN   = 4'd2,
    REG_REVERSE     = 4'd3,
    REG_REF_START   = 4'd4,
    REG_REF_END     = 4'd5,
    REG_SAMPLE_STEP = 4'd6,
    REG_EXTENSION   = 4'd7
  } cfg_reg_e;

  // Which residue the shared remainder unit is computing.
  typedef enum logic [1:0] {
    RES_CURSOR = 2'd0,
    RES_START  = 2'd1,
    RES_EXT    = 2'd2
  } res_sel_e;

  // One alignment operation.
  typedef struct packed {
    logic     first_op;
    edit_op_e edit_op;
  } in_item_t;

  // One sampled point.
  typedef struct packed {
    logic [OUT_POS_WIDTH-1:0] ref_pos;
    logic [OUT_POS_WIDTH-1:0] query_pos;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic     run;
    logic     div_start;
    res_sel_e sel;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cfg_write;
    logic div_done;
  } ctrl_stat_t;

endpackage

// ===== src/awps_rem_div.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit per cycle.
// Depends on nothing but its parameters.
module awps_rem_div #(
  parameter int DIVIDEND_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVIDEND_WIDTH-1:0] dividend_i,
  input  logic [DIVISOR_WIDTH-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DIVISOR_WIDTH-1:0]  rem_o
);

  localparam int CNT_W = (DIVIDEND_WIDTH > 1) ? $clog2(DIVIDEND_WIDTH) : 1;

  logic [DIVIDEND_WIDTH-1:0] shift_q;
  logic [DIVISOR_WIDTH-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;
  logic [DIVISOR_WIDTH:0]    trial;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial = {rem_q, shift_q[DIVIDEND_WIDTH-1]};
    if (trial >= {1'b0, divisor_i}) begin
      trial = trial - {1'b0, divisor_i};
    end
    rem_d = trial[DIVISOR_WIDTH-1:0];
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIVIDEND_WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Dividend shifter and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[DIVIDEND_WIDTH-2:0], 1'b0};
      rem_q   <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/awps_ctrl.sv =====
// Sequencer of the sampler: runs the residue pass after configuration writes.
// Depends on awps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module awps_ctrl
  import awps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_RUN,
    S_CUR,
    S_START,
    S_EXT
  } state_e;

  state_e    state_q;
  ctrl_cmd_t cmd_q;

  // State and registered commands. A configuration write always restarts
  // the pass with the cursor residue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      cmd_q   <= '{run: 1'b1, div_start: 1'b0, sel: RES_CURSOR};
    end else begin
      if (stat_i.cfg_write) begin
        state_q <= S_CUR;
        cmd_q   <= '{run: 1'b0, div_start: 1'b1, sel: RES_CURSOR};
      end else begin
        unique case (state_q)
          S_RUN: begin
          end
          S_CUR: begin
            if (stat_i.div_done) begin
              state_q <= S_START;
              cmd_q   <= '{run: 1'b0, div_start: 1'b1, sel: RES_START};
            end else begin
              cmd_q.div_start <= 1'b0;
            end
          end
          S_START: begin
            if (stat_i.div_done) begin
              state_q <= S_EXT;
              cmd_q   <= '{run: 1'b0, div_start: 1'b1, sel: RES_EXT};
            end else begin
              cmd_q.div_start <= 1'b0;
            end
          end
          S_EXT: begin
            if (stat_i.div_done) begin
              state_q <= S_RUN;
              cmd_q   <= '{run: 1'b1, div_start: 1'b0, sel: RES_CURSOR};
            end else begin
              cmd_q.div_start <= 1'b0;
            end
          end
          default: begin
            state_q <= S_RUN;
          end
        endcase
      end
    end
  end

  assign cmd_o = cmd_q;

  `AWPS_ASSERT(a_restart, stat_i.cfg_write |=> cmd_q.div_start, "no residue restart")
  `AWPS_NEVER(a_no_done_in_run, stat_i.div_done && state_q == S_RUN, "done while running")

endmodule

// ===== src/awps_datapath.sv =====
// Datapath of the sampler: registers, cursors, residues, boundary test, result queue.
// Depends on awps_pkg, awps_rem_div and assert_macros.svh.
`include "assert_macros.svh"

module awps_datapath
  import awps_pkg::*;
#(
  parameter int POS_WIDTH  = POS_WIDTH_DEF,
  parameter int STEP_WIDTH = STEP_WIDTH_DEF,
  parameter int DATA_WIDTH = POS_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  output ctrl_stat_t               stat_o,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [DATA_WIDTH-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  in_item_t                 in_item_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output out_item_t                out_item_o,
  input  logic                     out_stall_i
);

  localparam int MAG_W  = STEP_WIDTH + 1;
  localparam int LANE_W = DATA_WIDTH + 2;
  // Lanes that test a boundary above the position: p+1, p+e+1, p+e, p+e-1.
  localparam logic [NUM_LANES-1:0] LANE_ADD = 9'b1_1100_0001;

  // Configuration registers.
  logic [POS_WIDTH-1:0]  query_start_q, query_end_q, query_len_q;
  logic                  reverse_q;
  logic [POS_WIDTH-1:0]  ref_start_q, ref_end_q;
  logic [STEP_WIDTH-1:0] sample_step_q, extension_q;

  // Walk state and residues modulo the step.
  logic [POS_WIDTH-1:0]  ref_cursor_q, ref_cursor_d;
  logic [POS_WIDTH-1:0]  query_cursor_q, query_cursor_d;
  logic [STEP_WIDTH-1:0] phase_q, phase_d;
  logic [STEP_WIDTH-1:0] start_res_q, ext_res_q;

  // Result queue: head drives the port, skid catches one more.
  logic      head_valid_q, head_valid_d, skid_valid_q, skid_valid_d;
  out_item_t head_q, head_d, skid_q, skid_d;

  logic                  div_done;
  logic [STEP_WIDTH-1:0] div_rem;
  logic [DATA_WIDTH-1:0] div_operand;
  logic                  div_done_ok;

  logic                  accept, push, pop, hit_any, ref_adv, query_adv, test_pos;
  logic [POS_WIDTH-1:0]  pos, qpos;
  logic [STEP_WIDTH-1:0] res;
  logic [STEP_WIDTH-1:0] res_one, res_ep, res_em;
  logic [MAG_W-1:0]      mag_e;
  logic [MAG_W-1:0]      lane_mag [NUM_LANES];
  logic [STEP_WIDTH-1:0] lane_res [NUM_LANES];
  logic [LANE_W-1:0]     lane_b   [NUM_LANES];
  logic [NUM_LANES-1:0]  lane_en, lane_hit;
  logic [STEP_WIDTH:0]   phase_inc;
  out_item_t             new_item;

  // Residue of a negated offset.
  function automatic logic [STEP_WIDTH-1:0] neg_res(input logic [STEP_WIDTH-1:0] x,
                                                    input logic [STEP_WIDTH-1:0] m);
    return (x == '0) ? '0 : (m - x);
  endfunction

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_start_q <= '0;
      query_end_q   <= '0;
      query_len_q   <= '0;
      reverse_q     <= 1'b0;
      ref_start_q   <= '0;
      ref_end_q     <= '0;
      sample_step_q <= STEP_WIDTH'(SAMPLE_STEP_RST);
      extension_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_QUERY_START: query_start_q <= cfg_data_i[POS_WIDTH-1:0];
        REG_QUERY_END:   query_end_q   <= cfg_data_i[POS_WIDTH-1:0];
        REG_QUERY_LEN:   query_len_q   <= cfg_data_i[POS_WIDTH-1:0];
        REG_REVERSE:     reverse_q     <= cfg_data_i[0];
        REG_REF_START:   ref_start_q   <= cfg_data_i[POS_WIDTH-1:0];
        REG_REF_END:     ref_end_q     <= cfg_data_i[POS_WIDTH-1:0];
        REG_SAMPLE_STEP: sample_step_q <= cfg_data_i[STEP_WIDTH-1:0];
        REG_EXTENSION:   extension_q   <= cfg_data_i[STEP_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Shared remainder unit for the residue pass.
  always_comb begin
    unique case (cmd_i.sel)
      RES_CURSOR: div_operand = DATA_WIDTH'(ref_cursor_q);
      RES_START:  div_operand = DATA_WIDTH'(ref_start_q);
      RES_EXT:    div_operand = DATA_WIDTH'(extension_q);
      default:    div_operand = '0;
    endcase
  end

  awps_rem_div #(
    .DIVIDEND_WIDTH (DATA_WIDTH),
    .DIVISOR_WIDTH  (STEP_WIDTH)
  ) u_rem_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_operand),
    .divisor_i  (sample_step_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // A finish seen while a restart is issued belongs to an aborted run.
  assign div_done_ok = div_done && !cmd_i.div_start;
  assign stat_o      = '{cfg_write: cfg_valid_i, div_done: div_done_ok};

  // Operands of the current operation; a first operation reloads them.
  always_comb begin
    if (in_item_i.first_op) begin
      pos  = ref_start_q;
      res  = start_res_q;
      qpos = reverse_q ? (query_len_q - query_end_q) : query_start_q;
    end else begin
      pos  = ref_cursor_q;
      res  = phase_q;
      qpos = query_cursor_q;
    end
  end

  // Residues of the tested offsets 1, e-1, e and e+1.
  always_comb begin
    res_one = (sample_step_q == STEP_WIDTH'(1)) ? '0 : STEP_WIDTH'(1);
    res_ep  = (ext_res_q == sample_step_q - STEP_WIDTH'(1)) ? '0 : ext_res_q + STEP_WIDTH'(1);
    res_em  = (ext_res_q == '0) ? sample_step_q - STEP_WIDTH'(1) : ext_res_q - STEP_WIDTH'(1);
    mag_e   = MAG_W'(extension_q);

    lane_mag[0] = MAG_W'(1);        lane_res[0] = neg_res(res_one, sample_step_q);
    lane_mag[1] = '0;               lane_res[1] = '0;
    lane_mag[2] = MAG_W'(1);        lane_res[2] = res_one;
    lane_mag[3] = mag_e - MAG_W'(1); lane_res[3] = res_em;
    lane_mag[4] = mag_e;            lane_res[4] = ext_res_q;
    lane_mag[5] = mag_e + MAG_W'(1); lane_res[5] = res_ep;
    lane_mag[6] = mag_e + MAG_W'(1); lane_res[6] = neg_res(res_ep, sample_step_q);
    lane_mag[7] = mag_e;            lane_res[7] = neg_res(ext_res_q, sample_step_q);
    lane_mag[8] = mag_e - MAG_W'(1); lane_res[8] = neg_res(res_em, sample_step_q);

    lane_en = {{(NUM_LANES - 3){extension_q != '0}}, 3'b111};
  end

  // Each lane checks that its candidate boundary is a step multiple inside
  // the reference window; a borrow or carry lands outside the window.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (LANE_ADD[i]) begin
        lane_b[i] = LANE_W'(pos) + LANE_W'(lane_mag[i]);
      end else begin
        lane_b[i] = LANE_W'(pos) - LANE_W'(lane_mag[i]);
      end
      lane_hit[i] = lane_en[i] && (res == lane_res[i])
                    && (lane_b[i] >= LANE_W'(ref_start_q))
                    && (lane_b[i] < LANE_W'(ref_end_q));
    end
    hit_any = (|lane_hit) && (sample_step_q != '0) && (pos < ref_end_q);
  end

  // Cursor and phase advance.
  always_comb begin
    accept    = in_valid_i && !in_stall_o;
    test_pos  = (in_item_i.edit_op != OP_INS);
    ref_adv   = (in_item_i.edit_op != OP_INS);
    query_adv = (in_item_i.edit_op != OP_DEL);
    phase_inc = {1'b0, res} + MAG_W'(1);

    ref_cursor_d   = ref_adv ? pos + POS_WIDTH'(1) : pos;
    query_cursor_d = query_adv ? qpos + POS_WIDTH'(1) : qpos;
    if (!ref_adv) begin
      phase_d = res;
    end else if ((&pos) || (phase_inc == {1'b0, sample_step_q})) begin
      phase_d = '0;
    end else begin
      phase_d = phase_inc[STEP_WIDTH-1:0];
    end

    push     = accept && test_pos && hit_any;
    new_item = '{ref_pos: OUT_POS_WIDTH'(pos), query_pos: OUT_POS_WIDTH'(qpos)};
  end

  // Walk state; the residue pass fills the residues while no item enters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cursor_q   <= '0;
      query_cursor_q <= '0;
      phase_q        <= '0;
      start_res_q    <= '0;
      ext_res_q      <= '0;
    end else if (accept) begin
      ref_cursor_q   <= ref_cursor_d;
      query_cursor_q <= query_cursor_d;
      phase_q        <= phase_d;
    end else if (div_done_ok) begin
      unique case (cmd_i.sel)
        RES_CURSOR: phase_q     <= div_rem;
        RES_START:  start_res_q <= div_rem;
        RES_EXT:    ext_res_q   <= div_rem;
        default: begin
        end
      endcase
    end
  end

  // Two-entry result queue.
  always_comb begin
    pop          = head_valid_q && !out_stall_i;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        head_d = new_item;
      end else begin
        head_valid_d = 1'b0;
      end
    end else if (push) begin
      if (head_valid_q) begin
        skid_valid_d = 1'b1;
        skid_d       = new_item;
      end else begin
        head_valid_d = 1'b1;
        head_d       = new_item;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = !cmd_i.run || skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_item_o  = head_q;

  `AWPS_NEVER(a_skid_needs_head, skid_valid_q && !head_valid_q, "skid without head")
  `AWPS_NEVER(a_no_push_when_full, push && skid_valid_q, "result pushed into a full queue")

endmodule

// ===== src/alignment_window_point_sampler.sv =====
// Top level of the alignment window point sampler.
// Depends on awps_pkg, awps_ctrl and awps_datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o | in_data_i  (first_op, edit_op)
//   out     | out_valid_o/out_stall_i | out_data_o (ref_pos, query_pos)
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One operation is taken per cycle while in is not stalled; a sampled point is
// registered into a two-entry queue (head and skid) whose head drives out.
// A configuration write starts a residue pass in the bit-serial remainder
// unit (cursor, window start, extension), during which in is stalled.
// After reset the residues are already valid and operations are taken at once.
// in is also stalled while both queue entries wait on a stalled out.
module alignment_window_point_sampler
  import awps_pkg::*;
#(
  parameter int POS_WIDTH  = POS_WIDTH_DEF,
  parameter int STEP_WIDTH = STEP_WIDTH_DEF,
  localparam int DATA_WIDTH = (POS_WIDTH > STEP_WIDTH) ? POS_WIDTH : STEP_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [DATA_WIDTH-1:0]    cfg_data_i
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Registers are always writable; the pass restarts on every write.
  assign cfg_ready_o = 1'b1;

  awps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  awps_datapath #(
    .POS_WIDTH  (POS_WIDTH),
    .STEP_WIDTH (STEP_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== verif/alignment_window_point_sampler_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for alignment_window_point_sampler.
// Depends on awps_pkg and the sampler RTL; a scoreboard class predicts the sampled points.

module alignment_window_point_sampler_test
  import awps_pkg::*;
;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_PAD   = 4;
  localparam int unsigned RANDOM_OPS  = 850;

  // Tracks the alignment walk and holds the points still owed by the block.
  class point_scoreboard;
    logic [31:0] q_begin, q_fin, q_len, win_lo, win_hi;
    logic        rev;
    logic [15:0] step, ext;
    logic [31:0] ref_at, qry_at;
    out_item_t   points_due[$];
    int          failures;

    function new();
      q_begin  = '0;
      q_fin    = '0;
      q_len    = '0;
      rev      = 1'b0;
      win_lo   = '0;
      win_hi   = '0;
      step     = 16'(SAMPLE_STEP_RST);
      ext      = '0;
      ref_at   = '0;
      qry_at   = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] v);
      case (cfg_reg_e'(idx))
        REG_QUERY_START: q_begin = v;
        REG_QUERY_END:   q_fin = v;
        REG_QUERY_LEN:   q_len = v;
        REG_REVERSE:     rev = v[0];
        REG_REF_START:   win_lo = v;
        REG_REF_END:     win_hi = v;
        REG_SAMPLE_STEP: step = v[15:0];
        REG_EXTENSION:   ext = v[15:0];
        default: ;
      endcase
    endfunction

    // A boundary is a multiple of the step inside the reference overlap.
    function bit on_boundary(longint b);
      if (step == 0 || b < 0) return 1'b0;
      return (b % step == 0) && (b >= {32'b0, win_lo}) && (b < {32'b0, win_hi});
    endfunction

    // A position is sampled when it lies within one of a boundary or of a
    // boundary shifted by plus or minus the extension.
    function bit is_sampled(logic [31:0] p);
      longint pos;
      longint center [3];
      int     n;
      if (step == 0 || p >= win_hi) return 1'b0;
      pos       = p;
      center[0] = 0;
      center[1] = ext;
      center[2] = -center[1];
      n = (ext != 0) ? 3 : 1;
      for (int i = 0; i < n; i++) begin
        for (int d = -1; d <= 1; d++) begin
          if (on_boundary(pos - (center[i] + d))) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Advances the walk by one accepted request and queues any sampled point.
    function void note_request(in_item_t it);
      out_item_t pt;
      if (it.first_op) begin
        ref_at = win_lo;
        qry_at = rev ? (q_len - q_fin) : q_begin;
      end
      if (it.edit_op != OP_INS && is_sampled(ref_at)) begin
        pt.ref_pos   = ref_at;
        pt.query_pos = qry_at;
        points_due.insert(points_due.size(), pt);
      end
      case (it.edit_op)
        OP_MATCH, OP_MISMATCH: begin
          ref_at = ref_at + 1;
          qry_at = qry_at + 1;
        end
        OP_INS: qry_at = qry_at + 1;
        default: ref_at = ref_at + 1;
      endcase
    endfunction

    function void check_point(out_item_t got);
      out_item_t want;
      if (points_due.size() == 0) begin
        $error("unexpected point: ref_pos %0d query_pos %0d", got.ref_pos, got.query_pos);
        failures++;
        return;
      end
      want = points_due[0];
      points_due.delete(0);
      if (got.ref_pos !== want.ref_pos) begin
        $error("ref_pos: expected %0d, actual %0d", want.ref_pos, got.ref_pos);
        failures++;
      end
      if (got.query_pos !== want.query_pos) begin
        $error("query_pos: expected %0d, actual %0d", want.query_pos, got.query_pos);
        failures++;
      end
    endfunction

    function int pending();
      return points_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;

  point_scoreboard sb = new();

  alignment_window_point_sampler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check every accepted point and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_point(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: ends the run when no channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one operation request, idling first when the sender is throttled.
  task automatic send_op(input bit first, input edit_op_e code);
    in_item_t it;
    it.first_op = first;
    it.edit_op  = code;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(it);
  endtask

  // Writes one register; the caller lowers the valid after its last write.
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Stops sending and waits until the block has nothing left to report.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // Picks a window around a chosen boundary so that short walks hit points.
  task automatic shuffle_setup(input bit all_regs);
    logic [15:0]  stp, ex;
    logic [31:0]  anchor, lo, hi;
    int unsigned  pick;
    pick = $urandom_range(99);
    if (pick < 55) stp = 16'($urandom_range(40, 1));
    else if (pick < 75) stp = 16'($urandom_range(4000, 41));
    else if (pick < 90) stp = 16'($urandom_range(65535, 1));
    else stp = 16'hFFFF;
    pick = $urandom_range(99);
    if (pick < 45) ex = '0;
    else if (pick < 85) ex = 16'($urandom_range(20, 1));
    else if (pick < 95) ex = 16'($urandom_range(65535, 21));
    else ex = 16'hFFFF;
    anchor = stp * ($urandom % (32'hFFFF_FFFF / stp));
    pick = $urandom_range(99);
    if (pick < 50) lo = anchor - $urandom_range(30, 0);
    else if (pick < 85) lo = anchor - ex - $urandom_range(30, 1);
    else lo = $urandom;
    pick = $urandom_range(99);
    if (pick < 55) hi = lo + $urandom_range(200, 0);
    else if (pick < 80) hi = 32'hFFFF_FFFF;
    else hi = $urandom;

    if (all_regs || $urandom_range(3) != 0) write_reg(REG_QUERY_START, $urandom);
    if (all_regs || $urandom_range(3) != 0) write_reg(REG_QUERY_END, $urandom);
    if (all_regs || $urandom_range(3) != 0) write_reg(REG_QUERY_LEN, $urandom);
    if (all_regs || $urandom_range(3) != 0) write_reg(REG_REVERSE, $urandom);
    if (all_regs || $urandom_range(3) != 0) write_reg(REG_REF_START, lo);
    if (all_regs || $urandom_range(3) != 0) write_reg(REG_REF_END, hi);
    if (all_regs || $urandom_range(3) != 0) write_reg(REG_SAMPLE_STEP, {16'($urandom), stp});
    if (all_regs || $urandom_range(3) != 0) write_reg(REG_EXTENSION, {16'($urandom), ex});
    // Writes past the register list must leave every register alone.
    if ($urandom_range(4) == 0) write_reg(4'($urandom_range(15, 8)), $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n_ops;
    bit          tidy;
    sent  = 0;
    phase = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk from the reset cursors without a first operation; the empty
    // overlap after reset reports nothing.
    send_op(1'b0, OP_MATCH);
    send_op(1'b0, OP_INS);
    send_op(1'b0, OP_DEL);
    settle();

    // Reversed start that wraps, a window ending at the top of the range,
    // and a reference cursor that wraps past it.
    write_reg(REG_QUERY_START, 32'hFFFF_FFFE);
    write_reg(REG_QUERY_END, 32'd5);
    write_reg(REG_QUERY_LEN, 32'd2);
    write_reg(REG_REVERSE, 32'd1);
    write_reg(REG_REF_START, 32'hFFFF_FFFD);
    write_reg(REG_REF_END, 32'hFFFF_FFFF);
    write_reg(REG_SAMPLE_STEP, 32'd1);
    write_reg(REG_EXTENSION, 32'd0);
    cfg_valid_i <= 1'b0;
    send_op(1'b1, OP_MATCH);
    send_op(1'b0, OP_MISMATCH);
    send_op(1'b0, OP_INS);
    send_op(1'b0, OP_DEL);
    send_op(1'b0, OP_MATCH);
    settle();

    // A step that masks to zero leaves no boundaries at all.
    write_reg(REG_SAMPLE_STEP, 32'h0001_0000);
    write_reg(REG_REF_START, 32'd0);
    write_reg(4'hC, 32'h1234_5678);
    cfg_valid_i <= 1'b0;
    send_op(1'b1, OP_MATCH);
    send_op(1'b0, OP_DEL);
    settle();

    // Largest step and extension: offsets below zero match nothing, and
    // the query cursor wraps.
    write_reg(REG_SAMPLE_STEP, 32'h0000_FFFF);
    write_reg(REG_EXTENSION, 32'h0000_FFFF);
    write_reg(REG_REVERSE, 32'd0);
    cfg_valid_i <= 1'b0;
    send_op(1'b1, OP_MATCH);
    send_op(1'b0, OP_INS);
    send_op(1'b0, OP_MISMATCH);
    send_op(1'b0, OP_DEL);
    settle();

    // Random walks, mostly starting with a first operation, under each
    // idling pattern in turn.
    while (sent < RANDOM_OPS) begin
      case (phase % 5)
        1: begin
          send_idle_pct = 88;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 88;
        end
        3: begin
          send_idle_pct = 37;
          stall_pct     = 37;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      shuffle_setup(phase == 0);
      n_ops = $urandom_range(60, 20);
      tidy  = ($urandom_range(4) != 0);
      for (int unsigned i = 0; i < n_ops; i++) begin
        send_op(tidy ? (i == 0) : ($urandom_range(9) == 0), edit_op_e'($urandom_range(3)));
        sent++;
      end
      settle();
      phase++;
    end

    stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/awps_pkg.sv
src/awps_rem_div.sv
src/awps_ctrl.sv
src/awps_datapath.sv
src/alignment_window_point_sampler.sv
verif/alignment_window_point_sampler_test.sv
